// ===== sv/wis_pkg.sv =====
// Shared types and constants of the weighted index sampler.
package wis_pkg;

    localparam int unsigned OP_LOAD = 0;
    localparam int unsigned OP_PICK = 1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Input item as held in the queue between front and back.
    typedef struct packed {
        logic        op;
        logic        first_weight;
        logic [15:0] weight;
        logic [30:0] random_value;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_MOD,
        BK_SRCH_RD,
        BK_SRCH_CMP,
        BK_DONE
    } back_state_t;

endpackage

// ===== sv/wis_front.sv =====
// Input side: two-entry queue that holds accepted items for the back end.
module wis_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  wis_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_ready,
    output wis_pkg::item_t q_item
);

    wis_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Store the incoming transfer.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/wis_back.sv =====
// Execution side: prefix table, restoring modulo and binary search.
module wis_back #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned IDX_W       = 10,
    parameter int unsigned CNT_W       = 11,
    parameter int unsigned SUM_W       = 26
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  wis_pkg::item_t q_item,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [9:0]     res_index,
    output logic [1:0]     res_status
);

    localparam int unsigned RND_W = 31;
    localparam int unsigned BIT_W = $clog2(RND_W + 1);

    logic [SUM_W-1:0] prefix_mem [MAX_ENTRIES];
    logic [SUM_W-1:0] rd_data_reg;

    wis_pkg::back_state_t state_reg, state_next;
    wis_pkg::item_t       item_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [SUM_W-1:0]     total_reg;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [BIT_W-1:0]     bit_reg;
    logic [CNT_W-1:0]     lo_reg, hi_reg;
    logic [CNT_W-1:0]     mid;
    logic [9:0]           index_reg;
    logic [1:0]           status_reg;

    logic [CNT_W-1:0]     count_base;
    logic [SUM_W-1:0]     total_base, total_new;
    logic [SUM_W:0]       trial;
    logic                 full;

    assign count_base = item_reg.first_weight ? '0 : count_reg;
    assign total_base = item_reg.first_weight ? '0 : total_reg;
    assign total_new  = total_base + SUM_W'(item_reg.weight);
    assign full       = (count_base == CNT_W'(MAX_ENTRIES));
    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);

    // One restoring step: shift in the next random bit, subtract when it fits.
    always_comb begin
        trial    = {rem_reg, item_reg.random_value[bit_reg]};
        rem_next = SUM_W'(trial);
        if (trial >= {1'b0, total_reg}) begin
            rem_next = SUM_W'(trial - {1'b0, total_reg});
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wis_pkg::BK_IDLE: begin
                if (q_valid) begin
                    state_next = (q_item.op == 1'(wis_pkg::OP_LOAD))
                                 ? wis_pkg::BK_LOAD : wis_pkg::BK_MOD;
                end
            end
            wis_pkg::BK_LOAD: state_next = wis_pkg::BK_DONE;
            wis_pkg::BK_MOD: begin
                if (count_reg == '0 || total_reg == '0) begin
                    state_next = wis_pkg::BK_DONE;
                end else if (bit_reg == '0) begin
                    state_next = wis_pkg::BK_SRCH_RD;
                end
            end
            wis_pkg::BK_SRCH_RD: begin
                state_next = (lo_reg < hi_reg) ? wis_pkg::BK_SRCH_CMP : wis_pkg::BK_DONE;
            end
            wis_pkg::BK_SRCH_CMP: state_next = wis_pkg::BK_SRCH_RD;
            wis_pkg::BK_DONE: if (res_ready) state_next = wis_pkg::BK_IDLE;
            default: state_next = wis_pkg::BK_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        q_ready   = (state_reg == wis_pkg::BK_IDLE);
        res_valid = (state_reg == wis_pkg::BK_DONE);
    end
    assign res_index  = index_reg;
    assign res_status = status_reg;

    // Table write on load and registered table read during the search.
    always_ff @(posedge aclk) begin
        if (state_reg == wis_pkg::BK_LOAD && !full) begin
            prefix_mem[count_base[IDX_W-1:0]] <= total_new;
        end
        rd_data_reg <= prefix_mem[mid[IDX_W-1:0]];
    end

    // Hold control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wis_pkg::BK_IDLE;
            count_reg <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == wis_pkg::BK_LOAD && !full) begin
                count_reg <= count_base + 1'b1;
                total_reg <= total_new;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            wis_pkg::BK_IDLE: begin
                item_reg <= q_item;
                rem_reg  <= '0;
                bit_reg  <= BIT_W'(RND_W - 1);
            end
            wis_pkg::BK_LOAD: begin
                index_reg  <= '0;
                status_reg <= full ? wis_pkg::ST_FULL : wis_pkg::ST_OK;
            end
            wis_pkg::BK_MOD: begin
                if (count_reg == '0 || total_reg == '0) begin
                    index_reg  <= '0;
                    status_reg <= wis_pkg::ST_EMPTY;
                end else begin
                    rem_reg <= rem_next;
                    bit_reg <= bit_reg - 1'b1;
                    lo_reg  <= '0;
                    hi_reg  <= count_reg - 1'b1;
                end
            end
            wis_pkg::BK_SRCH_RD: begin
                if (!(lo_reg < hi_reg)) begin
                    index_reg  <= 10'(lo_reg);
                    status_reg <= wis_pkg::ST_OK;
                end
            end
            wis_pkg::BK_SRCH_CMP: begin
                if (rd_data_reg <= rem_reg) lo_reg <= mid + 1'b1;
                else                        hi_reg <= mid;
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/weighted_index_sampler_top.sv =====
// Weighted index sampler: a load writes one prefix-table entry; a pick runs a bit-serial
// modulo over the 31 random bits, then a binary search on the prefix RAM (a read state
// and a compare state per step, 10 steps for a full table, plus one final check).
// One item is executed at a time; a two-entry input queue keeps accepting while one runs,
// until it holds two items.
// Synchronous active-low reset empties the table and the queue; table RAM is not cleared.
module weighted_index_sampler_top #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // op, first_weight, weight[15:0], random_value[30:0], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // picked_index[9:0], status[1:0], pad
);

    localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned SUM_W = CNT_W + 15;

    wis_pkg::item_t in_item, q_item;
    logic           q_valid, q_ready;
    logic [9:0]     res_index;
    logic [1:0]     res_status;

    assign in_item.op           = s_tdata[0];
    assign in_item.first_weight = s_tdata[1];
    assign in_item.weight       = s_tdata[17:2];
    assign in_item.random_value = s_tdata[48:18];

    wis_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
        .q_valid, .q_ready, .q_item
    );

    wis_back #(
        .MAX_ENTRIES(MAX_ENTRIES), .IDX_W(IDX_W), .CNT_W(CNT_W), .SUM_W(SUM_W)
    ) u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_item,
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_index, .res_status
    );

    assign m_tdata = {4'd0, res_status, res_index};

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the weighted index sampler: random load/pick streams with a predictor.
module tb_top;

    localparam int unsigned TABLE_DEPTH = 1024;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // op, first_weight, weight[15:0], random_value[30:0], pad
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // picked_index[9:0], status[1:0], pad

    weighted_index_sampler_top #(.MAX_ENTRIES(TABLE_DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic [9:0]       picked_index;
        wis_pkg::status_t status;
    } pick_result_t;

    wis_pkg::item_t pending_items[$];
    pick_result_t   expected_picks[$];
    int             error_count = 0;
    bit             stim_done = 0;
    bit             in_fire = 0;
    bit             holdoff_done = 0;
    int             sender_pause = 0;   // -1: wait until all results are in
    int             receiver_holdoff = 0;

    // Predictor state
    logic [25:0] sum_table[TABLE_DEPTH];
    int unsigned table_count = 0;
    logic [25:0] weight_total = 0;

    // Pack an item with the first field in the lowest bits
    function automatic logic [55:0] pack_item(wis_pkg::item_t it);
        return {7'b0, it.random_value, it.weight, it.first_weight, it.op};
    endfunction

    function automatic pick_result_t predict_sample(wis_pkg::item_t it);
        pick_result_t r;
        int unsigned lo, hi, mid, target;
        r.picked_index = '0;
        r.status = wis_pkg::ST_OK;
        if (it.op == wis_pkg::OP_LOAD) begin
            if (it.first_weight) begin
                table_count = 0;
                weight_total = 0;
            end
            if (table_count >= TABLE_DEPTH) begin
                r.status = wis_pkg::ST_FULL;
            end else begin
                weight_total = weight_total + it.weight;
                sum_table[table_count] = weight_total;
                table_count++;
            end
        end else if (table_count == 0 || weight_total == 0) begin
            r.status = wis_pkg::ST_EMPTY;
        end else begin
            target = it.random_value % weight_total;
            lo = 0;
            hi = table_count - 1;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (sum_table[mid] <= target) lo = mid + 1;
                else hi = mid;
            end
            r.picked_index = lo[9:0];
        end
        return r;
    endfunction

    function automatic wis_pkg::item_t make_load(bit first, logic [15:0] w);
        wis_pkg::item_t it;
        it.op = 1'(wis_pkg::OP_LOAD);
        it.first_weight = first;
        it.weight = w;
        it.random_value = 31'($urandom());
        return it;
    endfunction

    function automatic wis_pkg::item_t make_pick(logic [30:0] rv);
        wis_pkg::item_t it;
        it.op = 1'(wis_pkg::OP_PICK);
        it.first_weight = 1'($urandom_range(0, 1));
        it.weight = 16'($urandom());
        it.random_value = rv;
        return it;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Clock and reset
    initial aclk = 0;
    always #10 aclk = ~aclk;

    initial begin
        aresetn = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
    end

    // Fill the stimulus queue
    initial begin
        int n, w;
        // Directed: empty pick, extreme weights, zero weight, restart
        pending_items.push_back(make_pick(31'h7FFFFFFF));
        pending_items.push_back(make_load(1'b0, 16'hFFFF));
        pending_items.push_back(make_pick(31'd0));
        pending_items.push_back(make_pick(31'h7FFFFFFF));
        pending_items.push_back(make_load(1'b1, 16'd0));
        pending_items.push_back(make_pick(31'd5));
        pending_items.push_back(make_load(1'b0, 16'd1));
        pending_items.push_back(make_load(1'b0, 16'd0));
        pending_items.push_back(make_load(1'b0, 16'd2));
        for (int r = 0; r < 4; r++) pending_items.push_back(make_pick(31'(r)));
        pending_items.push_back(make_load(1'b1, 16'hFFFF));
        pending_items.push_back(make_load(1'b0, 16'd7));
        pending_items.push_back(make_load(1'b0, 16'hFFFF));
        pending_items.push_back(make_pick(31'h7FFFFFFF));
        pending_items.push_back(make_pick(31'($urandom())));
        pending_items.push_back(make_load(1'b1, 16'd3));
        pending_items.push_back(make_pick(31'h2AAAAAAA));
        // Random: mostly small tables reloaded, then picks
        while (pending_items.size() < 840) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 12);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 3))
                    0: w = $urandom_range(0, 3);
                    1: w = 16'hFFFF - $urandom_range(0, 3);
                    default: w = $urandom_range(0, 65535);
                endcase
                pending_items.push_back(make_load(k == 0 ? 1'b1 : $urandom_range(0, 15) == 0,
                                                  16'(w)));
            end
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++)
                pending_items.push_back(make_pick(31'(($urandom_range(0, 4) == 0) ?
                    $urandom_range(0, 20) : $urandom())));
        end
    end

    // Note whether the input transfer completed at this rising edge
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
    end

    // Driver: present items at the falling edge, honoring random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (s_tvalid && !in_fire) begin
            // hold the current transfer
        end else if (sender_pause > 0) begin
            s_tvalid <= 1'b0;
            sender_pause <= sender_pause - 1;
        end else if (sender_pause < 0) begin
            s_tvalid <= 1'b0;
            if (expected_picks.size() == 0) sender_pause <= 0;
        end else if (pending_items.size() > 0) begin
            wis_pkg::item_t it;
            it = pending_items.pop_front();
            expected_picks.push_back(predict_sample(it));
            s_tvalid <= 1'b1;
            s_tdata  <= pack_item(it);
            if (pending_items.size() == 300) sender_pause <= -1;
            else sender_pause <= random_gap();
        end else begin
            s_tvalid <= 1'b0;
            stim_done <= 1'b1;
        end
    end

    // Receiver backpressure, with one long hold-off while the sender keeps going
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (receiver_holdoff > 0) begin
            m_tready <= 1'b0;
            receiver_holdoff <= receiver_holdoff - 1;
        end else if (!holdoff_done && pending_items.size() == 600) begin
            m_tready <= 1'b0;
            receiver_holdoff <= 800;
            holdoff_done <= 1'b1;
        end else begin
            m_tready <= (random_gap() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_picks.size() == 0) begin
                $error("unexpected result transfer: tdata %h", m_tdata);
                error_count++;
            end else begin
                pick_result_t want;
                want = expected_picks.pop_front();
                if (m_tdata[9:0] !== want.picked_index) begin
                    $error("picked_index: expected %0d, actual %0d",
                           want.picked_index, m_tdata[9:0]);
                    error_count++;
                end
                if (m_tdata[11:10] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[11:10]);
                    error_count++;
                end
            end
        end
    end

    // End of run
    initial begin
        wait (stim_done);
        wait (expected_picks.size() == 0);
        repeat (100) @(posedge aclk);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Timeout
    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
sv/wis_pkg.sv
sv/wis_front.sv
sv/wis_back.sv
sv/weighted_index_sampler_top.sv
verif/tb_top.sv
